// ----- src/dcf_pkg.sv -----
// Package: shared constants and codes of the DCF backoff timer.
`timescale 1ns / 1ps

package dcf_pkg;

   localparam int TIME_BITS_DEF = 48;   // default width of the internal time count
   localparam int OUT_TIME_W    = 48;   // width of time values on the ports
   localparam int SLOT_W        = 16;
   localparam int DIFS_W        = 20;
   localparam int REMAIN_W      = 32;
   localparam int FRAC_W        = 16;
   localparam int CW_W          = 10;
   localparam int SLOTS_W       = 10;
   localparam int PROD_W        = FRAC_W + CW_W;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 20;

   localparam logic [SLOT_W-1:0] SLOT_RESET = 16'd20000;
   localparam logic [DIFS_W-1:0] DIFS_RESET = 20'd50000;

   // Rounding term for ceil(frac * cw / 65536).
   localparam logic [PROD_W-1:0] ROUND_UP = PROD_W'(65535);

   typedef enum logic [2:0] {
      KIND_START    = 3'd0,
      KIND_PAUSE    = 3'd1,
      KIND_RESUME   = 3'd2,
      KIND_STOP     = 3'd3,
      KIND_SET_WAIT = 3'd4
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SLOT_TIME = 1'b0,
      REG_DIFS      = 1'b1
   } csr_index_type;

endpackage

// ----- src/dcf_backoff_timer.sv -----
// Top level: DCF backoff timer with a shared add/subtract unit and a serial remainder loop.
//
// Usage
//   Commands arrive one beat at a time on the req_ channel (valid/ready) and each one
//   produces exactly one beat on the rsp_ channel (valid/ready), in command order.
//   Kinds: start, pause, resume, stop, set wait; codes 5 to 7 leave the state alone.
//   The csr_ channel writes slot time (index 0) and DIFS (index 1); it is always ready
//   and must only be used while no command is in flight.
// Steps from accept to rsp_valid: stop, set wait and unknown codes go straight to the
//   final step; resume does two adds; start draws the slot count, multiplies it by the
//   slot time and adds; pause adds the wait end, takes the elapsed time, runs the
//   remainder loop (skipped when the slot time is zero), cuts to whole slots and clamps.
//   The loop retires one dividend bit per cycle (18-bit trial subtract of the slot time).
// Throughput: one command at a time; req_ready is high only in the idle state. A new
//   command is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears all timer state, drops rsp_valid and loads
//   the slot time and DIFS defaults. When the receiver stalls, the finished result
//   holds in the output register and the next command stalls in its final step.
`timescale 1ns / 1ps

module dcf_backoff_timer
   import dcf_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   // command channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_kind,
   input  logic [OUT_TIME_W-1:0]   req_now_ns,
   input  logic [FRAC_W-1:0]       req_rand_fraction,
   input  logic [CW_W-1:0]         req_contention_window,
   input  logic                    req_channel_idle,
   input  logic [REMAIN_W-1:0]     req_wait_value_ns,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_timeout_valid,
   output logic [OUT_TIME_W-1:0]   rsp_timeout_ns,
   output logic                    rsp_running,
   output logic                    rsp_paused,
   output logic [REMAIN_W-1:0]     rsp_remaining_ns
);

   localparam int CNT_BITS = $clog2(TIME_BITS);

   typedef logic [TIME_BITS-1:0] time_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_SLOTS,
      S_MUL_REMAIN,
      S_START_SUM,
      S_PAUSE_BASE,
      S_PAUSE_ELAPSED,
      S_PAUSE_DIV,
      S_PAUSE_CUT,
      S_PAUSE_CLAMP,
      S_RESUME_SUM,
      S_RESUME_WAIT,
      S_DONE
   } state_type;

   // sequencer and output register
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_tv_ff, rsp_tv_in;
   logic [OUT_TIME_W-1:0] rsp_tmo_ff, rsp_tmo_in;
   logic                  rsp_run_ff, rsp_run_in;
   logic                  rsp_pause_ff, rsp_pause_in;
   logic [REMAIN_W-1:0]   rsp_remain_ff, rsp_remain_in;

   // configuration
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [DIFS_W-1:0]     difs_ff, difs_in;

   // timer state
   logic                  on_ff, on_in;
   logic                  pause_ff, pause_in;
   time_type              count_start_ff, count_start_in;
   logic [REMAIN_W-1:0]   remain_ff, remain_in;
   logic [REMAIN_W-1:0]   wait_ff, wait_in;

   // latched command
   kind_type              kind_ff, kind_in;
   time_type              now_ff, now_in;
   logic [FRAC_W-1:0]     frac_ff, frac_in;
   logic [CW_W-1:0]       cw_ff, cw_in;
   logic                  idle_ff, idle_in;
   logic [REMAIN_W-1:0]   wval_ff, wval_in;

   // work registers
   time_type              acc_ff, acc_in;
   time_type              el_ff, el_in;
   logic [SLOT_W-1:0]     rem_ff, rem_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [SLOTS_W-1:0]    slots_ff, slots_in;
   logic [REMAIN_W-1:0]   work_remain_ff, work_remain_in;

   // shared arithmetic
   logic [FRAC_W-1:0]     mul_a;
   logic [CW_W-1:0]       mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic [PROD_W-1:0]     mul_round;
   time_type              add_a, add_b;
   logic                  add_sub;
   logic [TIME_BITS:0]    add_full;
   time_type              add_sum;
   logic                  add_borrow;
   logic [SLOT_W:0]       div_shift;
   logic [SLOT_W+1:0]     div_trial;

   assign csr_ready         = 1'b1;
   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_timeout_valid = rsp_tv_ff;
   assign rsp_timeout_ns    = rsp_tmo_ff;
   assign rsp_running       = rsp_run_ff;
   assign rsp_paused        = rsp_pause_ff;
   assign rsp_remaining_ns  = rsp_remain_ff;

   // one 16x10 multiplier: frac*cw for the slot draw, then slots*slot_time
   always_comb begin
      if (state_ff == S_MUL_SLOTS) begin
         mul_a = frac_ff;
         mul_b = cw_ff;
      end else begin
         mul_a = slot_ff;
         mul_b = slots_ff;
      end
      mul_p     = PROD_W'(mul_a) * PROD_W'(mul_b);
      mul_round = mul_p + ROUND_UP;
   end

   // one add/subtract unit; borrow is the inverted carry out on a subtract
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      unique case (state_ff)
         S_START_SUM: begin
            add_a = now_ff;
            add_b = time_type'(work_remain_ff);
         end
         S_PAUSE_BASE: begin
            add_a = count_start_ff;
            add_b = time_type'(wait_ff);
         end
         S_PAUSE_ELAPSED: begin
            add_a   = now_ff;
            add_b   = acc_ff;
            add_sub = 1'b1;
         end
         S_PAUSE_CUT: begin
            add_a   = el_ff;
            add_b   = time_type'(rem_ff);
            add_sub = 1'b1;
         end
         S_PAUSE_CLAMP: begin
            add_a   = time_type'(remain_ff);
            add_b   = acc_ff;
            add_sub = 1'b1;
         end
         S_RESUME_SUM: begin
            add_a = now_ff;
            add_b = time_type'(remain_ff);
         end
         S_RESUME_WAIT: begin
            add_a = acc_ff;
            add_b = time_type'(wait_ff);
         end
         default: begin
            add_a = acc_ff;
         end
      endcase
      add_full   = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)}
                   + (TIME_BITS+1)'(add_sub);
      add_sum    = add_full[TIME_BITS-1:0];
      add_borrow = add_sub & ~add_full[TIME_BITS];
   end

   // restoring remainder step: bring down the next dividend bit, try the slot time
   assign div_shift = {rem_ff, acc_ff[TIME_BITS-1]};
   assign div_trial = {1'b0, div_shift} - {2'b00, slot_ff};

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_tv_in      = rsp_tv_ff;
      rsp_tmo_in     = rsp_tmo_ff;
      rsp_run_in     = rsp_run_ff;
      rsp_pause_in   = rsp_pause_ff;
      rsp_remain_in  = rsp_remain_ff;
      slot_in        = slot_ff;
      difs_in        = difs_ff;
      on_in          = on_ff;
      pause_in       = pause_ff;
      count_start_in = count_start_ff;
      remain_in      = remain_ff;
      wait_in        = wait_ff;
      kind_in        = kind_ff;
      now_in         = now_ff;
      frac_in        = frac_ff;
      cw_in          = cw_ff;
      idle_in        = idle_ff;
      wval_in        = wval_ff;
      acc_in         = acc_ff;
      el_in          = el_ff;
      rem_in         = rem_ff;
      cnt_in         = cnt_ff;
      slots_in       = slots_ff;
      work_remain_in = work_remain_ff;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_SLOT_TIME: slot_in = csr_wdata[SLOT_W-1:0];
            REG_DIFS:      difs_in = csr_wdata[DIFS_W-1:0];
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = kind_type'(req_kind);
               now_in  = time_type'(req_now_ns);
               frac_in = req_rand_fraction;
               cw_in   = req_contention_window;
               idle_in = req_channel_idle;
               wval_in = req_wait_value_ns;
               unique case (kind_type'(req_kind))
                  KIND_START:  state_in = S_MUL_SLOTS;
                  KIND_PAUSE:  state_in = S_PAUSE_BASE;
                  KIND_RESUME: state_in = S_RESUME_SUM;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_MUL_SLOTS: begin
            slots_in = mul_round[PROD_W-1 -: SLOTS_W];
            state_in = S_MUL_REMAIN;
         end
         S_MUL_REMAIN: begin
            work_remain_in = REMAIN_W'(mul_p);
            state_in       = S_START_SUM;
         end
         S_START_SUM: begin
            acc_in   = add_sum;
            state_in = S_DONE;
         end
         S_PAUSE_BASE: begin
            acc_in   = add_sum;
            state_in = S_PAUSE_ELAPSED;
         end
         S_PAUSE_ELAPSED: begin
            // clamp to zero when now is before the end of the wait
            acc_in = add_borrow ? '0 : add_sum;
            el_in  = add_borrow ? '0 : add_sum;
            rem_in = '0;
            cnt_in = CNT_BITS'(TIME_BITS - 1);
            if (slot_ff == '0) begin
               acc_in   = '0;
               state_in = S_PAUSE_CLAMP;
            end else begin
               state_in = S_PAUSE_DIV;
            end
         end
         S_PAUSE_DIV: begin
            acc_in = {acc_ff[TIME_BITS-2:0], 1'b0};
            rem_in = div_trial[SLOT_W+1] ? div_shift[SLOT_W-1:0] : div_trial[SLOT_W-1:0];
            if (cnt_ff == '0) begin
               state_in = S_PAUSE_CUT;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_PAUSE_CUT: begin
            // whole slots elapsed = elapsed - (elapsed mod slot)
            acc_in   = add_sum;
            state_in = S_PAUSE_CLAMP;
         end
         S_PAUSE_CLAMP: begin
            work_remain_in = add_borrow ? '0 : add_sum[REMAIN_W-1:0];
            state_in       = S_DONE;
         end
         S_RESUME_SUM: begin
            acc_in   = add_sum;
            state_in = S_RESUME_WAIT;
         end
         S_RESUME_WAIT: begin
            acc_in   = add_sum;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_tv_in = 1'b0;
               unique case (kind_ff)
                  KIND_START: begin
                     on_in          = 1'b1;
                     count_start_in = now_ff;
                     remain_in      = work_remain_ff;
                     pause_in       = ~idle_ff;
                     wait_in        = idle_ff ? '0 : REMAIN_W'(difs_ff);
                     rsp_tv_in      = idle_ff;
                  end
                  KIND_PAUSE: begin
                     remain_in = work_remain_ff;
                     pause_in  = 1'b1;
                     wait_in   = REMAIN_W'(difs_ff);
                  end
                  KIND_RESUME: begin
                     pause_in       = 1'b0;
                     count_start_in = now_ff;
                     rsp_tv_in      = 1'b1;
                  end
                  KIND_STOP: begin
                     on_in          = 1'b0;
                     pause_in       = 1'b0;
                     count_start_in = '0;
                     remain_in      = '0;
                     wait_in        = '0;
                  end
                  KIND_SET_WAIT: begin
                     wait_in = wval_ff;
                  end
                  default: begin
                  end
               endcase
               rsp_valid_in  = 1'b1;
               rsp_tmo_in    = rsp_tv_in ? OUT_TIME_W'(acc_ff) : '0;
               rsp_run_in    = on_in;
               rsp_pause_in  = pause_in;
               rsp_remain_in = remain_in;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         rsp_tv_ff      <= 1'b0;
         rsp_tmo_ff     <= '0;
         rsp_run_ff     <= 1'b0;
         rsp_pause_ff   <= 1'b0;
         rsp_remain_ff  <= '0;
         slot_ff        <= SLOT_RESET;
         difs_ff        <= DIFS_RESET;
         on_ff          <= 1'b0;
         pause_ff       <= 1'b0;
         count_start_ff <= '0;
         remain_ff      <= '0;
         wait_ff        <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_tv_ff      <= rsp_tv_in;
         rsp_tmo_ff     <= rsp_tmo_in;
         rsp_run_ff     <= rsp_run_in;
         rsp_pause_ff   <= rsp_pause_in;
         rsp_remain_ff  <= rsp_remain_in;
         slot_ff        <= slot_in;
         difs_ff        <= difs_in;
         on_ff          <= on_in;
         pause_ff       <= pause_in;
         count_start_ff <= count_start_in;
         remain_ff      <= remain_in;
         wait_ff        <= wait_in;
         kind_ff        <= kind_in;
         now_ff         <= now_in;
         frac_ff        <= frac_in;
         cw_ff          <= cw_in;
         idle_ff        <= idle_in;
         wval_ff        <= wval_in;
         acc_ff         <= acc_in;
         el_ff          <= el_in;
         rem_ff         <= rem_in;
         cnt_ff         <= cnt_in;
         slots_ff       <= slots_in;
         work_remain_ff <= work_remain_in;
      end
   end

   // a scheduled timeout always leaves the timer counting
   a_timeout_not_paused: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_tv_ff) |-> !rsp_pause_ff)
      else $error("timeout reported while paused");

   // no timeout time is shown without a timeout
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tv_ff) |-> (rsp_tmo_ff == '0))
      else $error("timeout time set without timeout");

   // every accepted command takes the sequencer out of idle in the following cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after accept");

endmodule
